>>> hdl/llrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package llrd_pkg;

    localparam int NUM_PORTS_DEF = 8;
    localparam int MAX_BATCH_DEF = 1024;
    localparam int PIDX_W        = 5;
    localparam int LOAD_W        = 16;
    localparam int WLOAD_W       = 17;
    localparam int COUNT_W       = 11;
    localparam int MASK_W        = 8;
    localparam int CMD_W         = 2;
    localparam int RPORT_W       = 3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_PORT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_DIST = 2'd1,
        CMD_PICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NOP,
        ST_SET,
        ST_COPY,
        ST_INC
    } store_op_t;

    typedef struct packed {
        store_op_t          op;
        logic [PIDX_W-1:0]  idx;
        logic [LOAD_W-1:0]  load;
    } store_ctl_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_PICK_DONE,
        S_COPY,
        S_FIND,
        S_INC,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

>>> hdl/llrd_argmin.sv
`timescale 1ns / 1ps
`default_nettype none
module llrd_argmin #(
    parameter int PW = $clog2(llrd_pkg::NUM_PORTS_DEF)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire llrd_pkg::scan_ctl_t           ctl,
    input  wire logic                          active,
    input  wire logic [llrd_pkg::WLOAD_W-1:0]  value,
    input  wire logic [PW-1:0]                 idx,
    output logic [PW-1:0]                      best_idx
);
    import llrd_pkg::*;

    logic               best_valid_reg;
    logic               best_valid_next;
    logic [WLOAD_W-1:0] best_load_reg;
    logic [WLOAD_W-1:0] best_load_next;
    logic [PW-1:0]      best_idx_reg;
    logic [PW-1:0]      best_idx_next;
    logic               take;

    // strict less-than keeps the lowest index on a tie
    assign take = ctl.step && active && (!best_valid_reg || (value < best_load_reg));

    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_load_next  = best_load_reg;
        best_idx_next   = best_idx_reg;
        if (ctl.clear)
        begin
            best_valid_next = 1'b0;
        end
        else if (take)
        begin
            best_valid_next = 1'b1;
            best_load_next  = value;
            best_idx_next   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
        end
        else
        begin
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_load_reg <= best_load_next;
        best_idx_reg  <= best_idx_next;
    end

    assign best_idx = best_idx_reg;

endmodule
`default_nettype wire

>>> hdl/llrd_store.sv
`timescale 1ns / 1ps
`default_nettype none
module llrd_store #(
    parameter int NUM_PORTS = llrd_pkg::NUM_PORTS_DEF,
    parameter int PW        = $clog2(llrd_pkg::NUM_PORTS_DEF)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire llrd_pkg::store_ctl_t          ctl,
    output logic [llrd_pkg::LOAD_W-1:0]        port_load_rd,
    output logic [llrd_pkg::WLOAD_W-1:0]       working_rd,
    output logic [llrd_pkg::COUNT_W-1:0]       alloc_rd
);
    import llrd_pkg::*;

    logic [LOAD_W-1:0]  port_load_reg    [NUM_PORTS];
    logic [WLOAD_W-1:0] working_load_reg [NUM_PORTS];
    logic [COUNT_W-1:0] allocation_reg   [NUM_PORTS];
    logic [PW-1:0]      idx;

    assign idx          = PW'(ctl.idx);
    assign port_load_rd = port_load_reg[idx];
    assign working_rd   = working_load_reg[idx];
    assign alloc_rd     = allocation_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                port_load_reg[i] <= '0;
            end
        end
        else if (ctl.op == ST_SET)
        begin
            port_load_reg[idx] <= ctl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            ST_COPY:
            begin
                working_load_reg[idx] <= {1'b0, port_load_rd};
                allocation_reg[idx]   <= '0;
            end
            ST_INC:
            begin
                working_load_reg[idx] <= working_rd + WLOAD_W'(1);
                allocation_reg[idx]   <= alloc_rd + COUNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/least_loaded_receive_distributor_top.sv
// Least-loaded receive distributor.
// Command channel: an item (command, port_index, load_value, request_count) is
// taken on a clock edge with start high and busy low. A set command stores a
// port load when port_index is below NUM_PORTS and gives no result. A pick
// scans every port once, one port a cycle through a single shared compare
// unit, and returns one result. A distribute copies the loads, then spends
// one scan plus one update on each request of the batch, then emits one beat
// per port in ascending order, last set on the final one. busy stays high
// until that final beat, and is low while it is on the result ports.
// With no active port, pick and distribute return a single error beat on the
// cycle after acceptance. Each result beat is on the result ports for one
// cycle, marked by result_strobe; the receiver cannot stall it.
// cfg_write_en writes the active port mask at once; write it only when idle.
// Reset clears the port loads and the mask and leaves the block idle.
`timescale 1ns / 1ps
`default_nettype none
module least_loaded_receive_distributor_top #(
    parameter int NUM_PORTS = llrd_pkg::NUM_PORTS_DEF,
    parameter int MAX_BATCH = llrd_pkg::MAX_BATCH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [llrd_pkg::MASK_W-1:0]   cfg_write_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [llrd_pkg::CMD_W-1:0]    command,
    input  wire logic [2:0]                    port_index,
    input  wire logic [llrd_pkg::LOAD_W-1:0]   load_value,
    input  wire logic [llrd_pkg::COUNT_W-1:0]  request_count,
    output logic                               result_strobe,
    output logic                               status,
    output logic [llrd_pkg::RPORT_W-1:0]       result_port,
    output logic [llrd_pkg::COUNT_W-1:0]       assigned_count,
    output logic                               last
);
    import llrd_pkg::*;

    localparam int PW = $clog2(NUM_PORTS);
    localparam int CW = $clog2(MAX_BATCH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(NUM_PORTS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [PW-1:0]      idx_reg;
    logic [PW-1:0]      idx_next;
    logic [CW-1:0]      remaining_reg;
    logic [CW-1:0]      remaining_next;

    logic               strobe_reg;
    logic               strobe_next;
    logic               status_reg;
    logic               status_next;
    logic [RPORT_W-1:0] port_reg;
    logic [RPORT_W-1:0] port_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               last_reg;
    logic               last_next;

    logic [NUM_PORTS-1:0] active_vec;
    logic                 any_active;
    logic                 accept;
    cmd_t                 cmd;
    logic                 set_in_range;
    logic [CW-1:0]        batch_size;

    store_ctl_t           store_ctl;
    scan_ctl_t            scan_ctl;
    logic [LOAD_W-1:0]    port_load_rd;
    logic [WLOAD_W-1:0]   working_rd;
    logic [COUNT_W-1:0]   alloc_rd;
    logic [WLOAD_W-1:0]   scan_value;
    logic [PW-1:0]        best_idx;

    for (genvar i = 0; i < NUM_PORTS; i++)
    begin : g_active
        if (i < MASK_W)
        begin : g_mask
            assign active_vec[i] = mask_reg[i];
        end
        else
        begin : g_none
            assign active_vec[i] = 1'b0;
        end
    end

    assign any_active   = |active_vec;
    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign cmd          = cmd_t'(command);
    assign set_in_range = (32'(port_index) < 32'(NUM_PORTS));
    assign batch_size   = (32'(request_count) > 32'(MAX_BATCH)) ? CW'(MAX_BATCH)
                                                               : CW'(request_count);
    assign scan_value   = (state_reg == S_PICK) ? {1'b0, port_load_rd} : working_rd;

    llrd_store #(
        .NUM_PORTS (NUM_PORTS),
        .PW        (PW)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (store_ctl),
        .port_load_rd (port_load_rd),
        .working_rd   (working_rd),
        .alloc_rd     (alloc_rd)
    );

    llrd_argmin #(
        .PW (PW)
    ) u_argmin (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .active   (active_vec[idx_reg]),
        .value    (scan_value),
        .idx      (idx_reg),
        .best_idx (best_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && any_active)
                begin
                    if (cmd == CMD_PICK)
                    begin
                        state_next = S_PICK;
                    end
                    else if (cmd == CMD_DIST)
                    begin
                        state_next = S_COPY;
                    end
                end
            end
            S_PICK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_PICK_DONE;
                end
            end
            S_PICK_DONE:
            begin
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = (remaining_reg == '0) ? S_EMIT : S_FIND;
                end
            end
            S_FIND:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                state_next = (remaining_reg == CW'(1)) ? S_EMIT : S_FIND;
            end
            S_EMIT:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        remaining_next = remaining_reg;
        store_ctl.op   = ST_NOP;
        store_ctl.idx  = PIDX_W'(idx_reg);
        store_ctl.load = load_value;
        scan_ctl.clear = 1'b0;
        scan_ctl.step  = 1'b0;
        strobe_next    = 1'b0;
        status_next    = STATUS_OK;
        port_next      = '0;
        count_next     = '0;
        last_next      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next       = '0;
                scan_ctl.clear = 1'b1;
                store_ctl.idx  = PIDX_W'(port_index);
                if (accept)
                begin
                    case (cmd)
                        CMD_SET:
                        begin
                            if (set_in_range)
                            begin
                                store_ctl.op = ST_SET;
                            end
                        end
                        CMD_PICK, CMD_DIST:
                        begin
                            remaining_next = batch_size;
                            if (!any_active)
                            begin
                                strobe_next = 1'b1;
                                status_next = STATUS_NO_PORT;
                                last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PICK:
            begin
                scan_ctl.step = 1'b1;
                idx_next      = idx_reg + PW'(1);
            end
            S_PICK_DONE:
            begin
                strobe_next = 1'b1;
                port_next   = RPORT_W'(best_idx);
                last_next   = 1'b1;
            end
            S_COPY:
            begin
                store_ctl.op   = ST_COPY;
                scan_ctl.clear = 1'b1;
                idx_next       = (idx_reg == LAST_IDX) ? '0 : idx_reg + PW'(1);
            end
            S_FIND:
            begin
                scan_ctl.step = 1'b1;
                idx_next      = (idx_reg == LAST_IDX) ? '0 : idx_reg + PW'(1);
            end
            S_INC:
            begin
                store_ctl.op   = ST_INC;
                store_ctl.idx  = PIDX_W'(best_idx);
                scan_ctl.clear = 1'b1;
                remaining_next = remaining_reg - CW'(1);
                idx_next       = '0;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                port_next   = RPORT_W'(idx_reg);
                count_next  = alloc_rd;
                last_next   = (idx_reg == LAST_IDX);
                idx_next    = idx_reg + PW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mask_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (cfg_write_en)
            begin
                mask_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        remaining_reg <= remaining_next;
        status_reg    <= status_next;
        port_reg      <= port_next;
        count_reg     <= count_next;
        last_reg      <= last_next;
    end

    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign result_port    = port_reg;
    assign assigned_count = count_reg;
    assign last           = last_reg;

endmodule
`default_nettype wire
